// ----- rtl/core/lfudfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lfudfp_pkg: shared types for the LFU dirty-first page replacer
// Item types, opcodes, status codes and the records passed along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package lfudfp_pkg;

	// Widest index, count and occupancy values over the supported parameter range
	localparam int IDX_W = 8;
	localparam int CNT_W = 32;
	localparam int OCC_W = 9;

	localparam logic [1:0] OP_REFERENCE = 2'd0;
	localparam logic [1:0] OP_DISCARD   = 2'd1;
	localparam logic [1:0] OP_EVICT     = 2'd2;
	localparam logic [1:0] OP_CLEAN     = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;

	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] page_key;
		logic        dirty_flag;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic        evicted_valid;
		logic [31:0] evicted_key;
		logic        evicted_dirty;
		logic [1:0]  status;
		logic [4:0]  occupancy;
	} out_item_t;

	// Scan record handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [31:0]      key;
		logic             found;
		logic [IDX_W-1:0] found_idx;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic             vic_valid;
		logic [IDX_W-1:0] vic_idx;
		logic             vic_dirty;
		logic [CNT_W-1:0] vic_count;
		logic [31:0]      vic_stamp;
		logic [31:0]      vic_key;
		logic [OCC_W-1:0] occ;
	} scan_t;

	// Update broadcast to all cells at the end of an item
	typedef struct packed {
		logic             evict_en;
		logic [IDX_W-1:0] evict_idx;
		logic             upd_en;
		logic [IDX_W-1:0] upd_idx;
		logic             upd_inc;
		logic             upd_dirty;
		logic             ins_en;
		logic [IDX_W-1:0] ins_idx;
		logic [31:0]      ins_key;
		logic             ins_dirty;
		logic [31:0]      ins_stamp;
	} commit_t;

endpackage
`default_nettype wire

// ----- rtl/core/lfudfp_cell.sv -----
// ----------------------------------------------------------------------------
// lfudfp_cell: one resident page slot
// Holds one entry, folds it into the passing scan record and applies commits.
// ----------------------------------------------------------------------------
`default_nettype none
module lfudfp_cell #(
	parameter int IDX = 0,
	parameter int COUNT_WIDTH = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lfudfp_pkg::scan_t       rec_in,
	output lfudfp_pkg::scan_t       rec_out,
	input  lfudfp_pkg::commit_t     commit
);

	localparam logic [lfudfp_pkg::IDX_W-1:0] MY_IDX = lfudfp_pkg::IDX_W'(IDX);

	logic                   valid_q;
	logic [31:0]            key_q;
	logic                   dirty_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [31:0]            stamp_q;
	lfudfp_pkg::scan_t      rec_q;
	lfudfp_pkg::scan_t      rec_d;
	logic [lfudfp_pkg::CNT_W-1:0] cnt_ext;
	logic                   better;

	assign cnt_ext = lfudfp_pkg::CNT_W'(cnt_q);

	// Rank this entry against the current victim candidate
	always_comb begin
		if (dirty_q != rec_in.vic_dirty) begin
			better = dirty_q;
		end else if (cnt_ext != rec_in.vic_count) begin
			better = cnt_ext < rec_in.vic_count;
		end else begin
			better = stamp_q < rec_in.vic_stamp;
		end
	end

	// Fold this entry into the record
	always_comb begin
		rec_d = rec_in;
		if (rec_in.valid && valid_q) begin
			rec_d.occ = rec_in.occ + 1'b1;
			if (key_q == rec_in.key && !rec_in.found) begin
				rec_d.found = 1'b1;
				rec_d.found_idx = MY_IDX;
			end
			if (!rec_in.vic_valid || better) begin
				rec_d.vic_valid = 1'b1;
				rec_d.vic_idx = MY_IDX;
				rec_d.vic_dirty = dirty_q;
				rec_d.vic_count = cnt_ext;
				rec_d.vic_stamp = stamp_q;
				rec_d.vic_key = key_q;
			end
		end
		if (rec_in.valid && !valid_q && !rec_in.free_found) begin
			rec_d.free_found = 1'b1;
			rec_d.free_idx = MY_IDX;
		end
	end

	// Advance the record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	assign rec_out = rec_q;

	// Valid bit: set on insert, otherwise drop on evict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (commit.ins_en && commit.ins_idx == MY_IDX) begin
				valid_q <= 1'b1;
			end else if (commit.evict_en && commit.evict_idx == MY_IDX) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (commit.ins_en && commit.ins_idx == MY_IDX) begin
			key_q   <= commit.ins_key;
			dirty_q <= commit.ins_dirty;
			cnt_q   <= COUNT_WIDTH'(1);
			stamp_q <= commit.ins_stamp;
		end else if (commit.upd_en && commit.upd_idx == MY_IDX) begin
			dirty_q <= commit.upd_dirty;
			if (commit.upd_inc && cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lfudfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfudfp_ctrl: item sequencer
// Accepts an item, launches the scan, decides the update and issues the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lfudfp_ctrl #(
	parameter int ENTRIES = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  lfudfp_pkg::in_item_t    in_data,
	output logic                    out_valid,
	input  wire                     out_stall,
	output lfudfp_pkg::out_item_t   out_data,
	input  wire                     cfg_wr_en,
	input  wire [4:0]               cfg_wr_data,
	output lfudfp_pkg::scan_t       scan_start,
	input  lfudfp_pkg::scan_t       scan_end,
	output lfudfp_pkg::commit_t     commit
);

	localparam int OW = lfudfp_pkg::OCC_W;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t                  state_q;
	lfudfp_pkg::in_item_t    item_q;
	lfudfp_pkg::scan_t       fin_q;
	lfudfp_pkg::out_item_t   out_q;
	logic                    out_valid_q;
	logic                    inject_q;
	logic [4:0]              cap_q;
	logic [31:0]             stamp_q;
	logic [OW-1:0]           cap_eff;
	logic                    in_acc;
	logic                    do_commit;
	lfudfp_pkg::out_item_t   res;
	logic                    ins;
	logic                    ev;
	logic [OW-1:0]           occ_after;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign do_commit = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Clamp capacity to 1..ENTRIES
	always_comb begin
		if (cap_q == 5'd0) begin
			cap_eff = OW'(1);
		end else if (OW'(cap_q) > OW'(ENTRIES)) begin
			cap_eff = OW'(ENTRIES);
		end else begin
			cap_eff = OW'(cap_q);
		end
	end

	// Launch record for the chain
	always_comb begin
		scan_start = '0;
		scan_start.valid = inject_q;
		scan_start.key = item_q.page_key;
	end

	// Decide the update and the result
	always_comb begin
		commit = '0;
		res = '0;
		ins = 1'b0;
		ev = 1'b0;
		commit.ins_key = item_q.page_key;
		commit.ins_dirty = item_q.dirty_flag;
		commit.ins_stamp = stamp_q;
		commit.upd_idx = fin_q.found_idx;
		commit.evict_idx = fin_q.vic_idx;
		case (item_q.opcode)
			lfudfp_pkg::OP_REFERENCE: begin
				if (fin_q.found) begin
					res.hit = 1'b1;
					commit.upd_en = 1'b1;
					commit.upd_inc = 1'b1;
					commit.upd_dirty = item_q.dirty_flag;
				end else begin
					ev = fin_q.occ >= cap_eff && fin_q.vic_valid;
					ins = fin_q.free_found || ev;
					if (ev && (!fin_q.free_found || fin_q.vic_idx < fin_q.free_idx)) begin
						commit.ins_idx = fin_q.vic_idx;
					end else begin
						commit.ins_idx = fin_q.free_idx;
					end
				end
			end
			lfudfp_pkg::OP_DISCARD: begin
				if (fin_q.found) begin
					res.hit = 1'b1;
					commit.evict_en = 1'b1;
					commit.evict_idx = fin_q.found_idx;
				end else begin
					res.status = lfudfp_pkg::ST_NOT_FOUND;
				end
			end
			lfudfp_pkg::OP_EVICT: begin
				if (fin_q.vic_valid) begin
					ev = 1'b1;
				end else begin
					res.status = lfudfp_pkg::ST_EMPTY;
				end
			end
			lfudfp_pkg::OP_CLEAN: begin
				if (fin_q.found) begin
					res.hit = 1'b1;
					commit.upd_en = 1'b1;
					commit.upd_dirty = 1'b0;
				end else begin
					res.status = lfudfp_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				res = '0;
			end
		endcase
		if (ev) begin
			commit.evict_en = 1'b1;
			res.evicted_valid = 1'b1;
			res.evicted_key = fin_q.vic_key;
			res.evicted_dirty = fin_q.vic_dirty;
		end
		commit.ins_en = ins;
		occ_after = fin_q.occ - OW'(commit.evict_en) + OW'(ins);
		res.occupancy = occ_after[4:0];
		if (!do_commit) begin
			commit.evict_en = 1'b0;
			commit.upd_en = 1'b0;
			commit.ins_en = 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inject_q <= 1'b0;
			out_valid_q <= 1'b0;
			stamp_q <= '0;
			cap_q <= lfudfp_pkg::CAPACITY_RESET;
		end else begin
			inject_q <= in_acc;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			// Raise on a new result, drop once the waiting result is taken
			if (do_commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end.valid) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (do_commit) begin
						state_q <= S_IDLE;
						if (ins) begin
							stamp_q <= stamp_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold item, final record and result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (state_q == S_SCAN && scan_end.valid) begin
			fin_q <= scan_end;
		end
		if (do_commit) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lfu_dirty_first_page_replacer_top.sv -----
// ----------------------------------------------------------------------------
// lfu_dirty_first_page_replacer_top: LFU page replacer, dirty pages first
// Row of ENTRIES slot cells with a scan record passed down the row.
// ----------------------------------------------------------------------------
// One item at a time: after acceptance the scan record passes through the row
// of slot cells, the final record is latched, then the update is committed and
// the result registered, later if an earlier result is still stalled. The
// input stalls until the result is issued, so the next item is accepted only
// once the previous item's result has been issued. The scan both
// finds the key and ranks the victim (dirty, then lowest count, then oldest
// stamp, then lowest slot). No clearing pass after reset.
`default_nettype none
module lfu_dirty_first_page_replacer_top #(
	parameter int ENTRIES = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  lfudfp_pkg::in_item_t    in_data,
	output logic                    out_valid,
	input  wire                     out_stall,
	output lfudfp_pkg::out_item_t   out_data,
	input  wire                     cfg_wr_en,
	input  wire [4:0]               cfg_wr_data
);

	lfudfp_pkg::scan_t   rec [ENTRIES+1];
	lfudfp_pkg::commit_t commit;

	// Sequencer
	lfudfp_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.scan_start(rec[0]), .scan_end(rec[ENTRIES]), .commit(commit)
	);

	// Row of slot cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfudfp_cell #(.IDX(i), .COUNT_WIDTH(COUNT_WIDTH)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.rec_in(rec[i]), .rec_out(rec[i+1]), .commit(commit)
		);
	end

endmodule
`default_nettype wire

// ----- rtl/core/lfudfp_checker.sv -----
// ----------------------------------------------------------------------------
// lfudfp_checker: port checks for the page replacer
// Result field consistency and one-item-at-a-time behavior.
// ----------------------------------------------------------------------------
`default_nettype none
module lfudfp_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     in_valid,
	input wire                     in_stall,
	input wire                     out_valid,
	input wire                     out_stall,
	input lfudfp_pkg::out_item_t   out_data
);

	// A taken item blocks the input until it is done
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after item");

	// No eviction means empty eviction fields
	a_ev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.evicted_valid |->
			out_data.evicted_key == 32'd0 && !out_data.evicted_dirty)
		else $error("eviction fields set without eviction");

	// A failed item neither hits nor evicts
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != lfudfp_pkg::ST_OK |->
			!out_data.hit && !out_data.evicted_valid)
		else $error("failed item hit or evicted");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind lfu_dirty_first_page_replacer_top lfudfp_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- bench/lfu_replacer_checker.sv -----
// ----------------------------------------------------------------------------
// lfu_replacer_checker: result checker for the LFU dirty-first page replacer
// Watches both channels, keeps its own page table and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module lfu_replacer_checker #(
	parameter int ENTRIES = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    in_stall,
	input  lfudfp_pkg::in_item_t   in_data,
	input  wire                    out_valid,
	input  wire                    out_stall,
	input  lfudfp_pkg::out_item_t  out_data,
	input  wire                    cfg_wr_en,
	input  wire [4:0]              cfg_wr_data,
	output int                     fail_count,
	output int                     pending
);

	localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF >> (32 - COUNT_WIDTH);

	// Shadow page table
	logic        pg_valid [ENTRIES];
	logic [31:0] pg_key   [ENTRIES];
	logic        pg_dirty [ENTRIES];
	logic [31:0] pg_count [ENTRIES];
	logic [31:0] pg_stamp [ENTRIES];
	logic [31:0] stamp_next;
	logic [4:0]  cap_reg;

	lfudfp_pkg::out_item_t expected_results[$];

	function automatic int find_page(logic [31:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (pg_valid[i] && pg_key[i] == key) return i;
		return -1;
	endfunction

	// Dirty first, then lowest count, then oldest stamp, then lowest slot
	function automatic int choose_victim();
		int best;
		best = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!pg_valid[i]) continue;
			if (best < 0) best = i;
			else if (pg_dirty[i] != pg_dirty[best]) begin
				if (pg_dirty[i]) best = i;
			end else if (pg_count[i] != pg_count[best]) begin
				if (pg_count[i] < pg_count[best]) best = i;
			end else if (pg_stamp[i] < pg_stamp[best]) best = i;
		end
		return best;
	endfunction

	function automatic int resident();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++) if (pg_valid[i]) n++;
		return n;
	endfunction

	function automatic lfudfp_pkg::out_item_t apply_item(lfudfp_pkg::in_item_t it);
		lfudfp_pkg::out_item_t r;
		int slot, vic, cap;
		r = '0;
		cap = cap_reg;
		if (cap == 0) cap = 1;
		if (cap > ENTRIES) cap = ENTRIES;
		case (it.opcode)
			lfudfp_pkg::OP_REFERENCE: begin
				slot = find_page(it.page_key);
				if (slot >= 0) begin
					r.hit = 1'b1;
					if (pg_count[slot] < COUNT_SAT) pg_count[slot]++;
					pg_dirty[slot] = it.dirty_flag;
				end else begin
					if (resident() >= cap) begin
						vic = choose_victim();
						if (vic >= 0) begin
							r.evicted_valid = 1'b1;
							r.evicted_key = pg_key[vic];
							r.evicted_dirty = pg_dirty[vic];
							pg_valid[vic] = 1'b0;
						end
					end
					for (int i = 0; i < ENTRIES; i++) begin
						if (!pg_valid[i]) begin
							pg_valid[i] = 1'b1;
							pg_key[i] = it.page_key;
							pg_dirty[i] = it.dirty_flag;
							pg_count[i] = 1;
							pg_stamp[i] = stamp_next;
							stamp_next = stamp_next + 1;
							break;
						end
					end
				end
			end
			lfudfp_pkg::OP_DISCARD: begin
				slot = find_page(it.page_key);
				if (slot >= 0) begin
					r.hit = 1'b1;
					pg_valid[slot] = 1'b0;
				end else r.status = lfudfp_pkg::ST_NOT_FOUND;
			end
			lfudfp_pkg::OP_EVICT: begin
				vic = choose_victim();
				if (vic >= 0) begin
					r.evicted_valid = 1'b1;
					r.evicted_key = pg_key[vic];
					r.evicted_dirty = pg_dirty[vic];
					pg_valid[vic] = 1'b0;
				end else r.status = lfudfp_pkg::ST_EMPTY;
			end
			default: begin
				slot = find_page(it.page_key);
				if (slot >= 0) begin
					r.hit = 1'b1;
					pg_dirty[slot] = 1'b0;
				end else r.status = lfudfp_pkg::ST_NOT_FOUND;
			end
		endcase
		r.occupancy = 5'(resident());
		return r;
	endfunction

	// Predict on accepted inputs, compare on accepted outputs
	always @(posedge clk or negedge arst_n) begin
		lfudfp_pkg::out_item_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) pg_valid[i] = 1'b0;
			stamp_next = '0;
			cap_reg = lfudfp_pkg::CAPACITY_RESET;
			fail_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, out_data);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_data.hit !== exp_r.hit
							|| out_data.evicted_valid !== exp_r.evicted_valid
							|| out_data.evicted_key !== exp_r.evicted_key
							|| out_data.evicted_dirty !== exp_r.evicted_dirty
							|| out_data.status !== exp_r.status
							|| out_data.occupancy !== exp_r.occupancy) begin
						$display("%0t: mismatch expected hit=%b ev=%b key=%h dirty=%b st=%0d occ=%0d",
							$realtime, exp_r.hit, exp_r.evicted_valid, exp_r.evicted_key,
							exp_r.evicted_dirty, exp_r.status, exp_r.occupancy);
						$display("%0t:          actual   hit=%b ev=%b key=%h dirty=%b st=%0d occ=%0d",
							$realtime, out_data.hit, out_data.evicted_valid, out_data.evicted_key,
							out_data.evicted_dirty, out_data.status, out_data.occupancy);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_item(in_data));
			if (cfg_wr_en) cap_reg = cfg_wr_data;
			pending = expected_results.size();
		end
	end
endmodule
`default_nettype wire

// ----- bench/tb_lfu_dirty_first_page_replacer_top.sv -----
// ----------------------------------------------------------------------------
// tb_lfu_dirty_first_page_replacer_top: testbench for the LFU page replacer
// Drives directed and random page traffic under several capacities with random
// gaps and output stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_lfu_dirty_first_page_replacer_top;

	localparam int ENTRIES = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int DRAIN_CYCLES = ENTRIES + 8;

	logic      clk, arst_n;
	logic      in_valid, in_stall, out_valid, out_stall;
	lfudfp_pkg::in_item_t  in_data;
	lfudfp_pkg::out_item_t out_data;
	logic      cfg_wr_en;
	logic [4:0] cfg_wr_data;
	int        fail_count, pending;
	int        item_total;
	logic [31:0] key_pool [8];

	lfu_dirty_first_page_replacer_top #(.ENTRIES(ENTRIES), .COUNT_WIDTH(COUNT_WIDTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	lfu_replacer_checker #(.ENTRIES(ENTRIES), .COUNT_WIDTH(COUNT_WIDTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall each waiting result for a randomly drawn wait, then take it
	initial begin
		int wait_n;
		out_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid) begin
				wait_n = $urandom_range(0, 5);
				repeat (wait_n) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
				out_stall <= 1'b1;
			end
		end
	end

	// Present one item and hold it until accepted
	task automatic send_item(logic [1:0] op, logic [31:0] key, logic dflag);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{opcode: op, page_key: key, dirty_flag: dflag};
		do @(posedge clk); while (in_stall);
		item_total++;
	endtask

	// Wait for all results, let the pipeline settle, then write capacity
	task automatic set_capacity(logic [4:0] cap);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(int count);
		logic [1:0] op;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) op = lfudfp_pkg::OP_REFERENCE;
			else if (pick == 6) op = lfudfp_pkg::OP_DISCARD;
			else if (pick == 7) op = lfudfp_pkg::OP_EVICT;
			else op = lfudfp_pkg::OP_CLEAN;
			if ($urandom_range(0, 9) == 0)
				send_item(op, $urandom(), 1'($urandom));
			else
				send_item(op, key_pool[$urandom_range(0, 7)] + $urandom_range(0, 20),
					1'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_total = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFE0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table cases, extremes of key, hit/miss, all opcodes
		send_item(lfudfp_pkg::OP_EVICT, 32'h0, 1'b0);
		send_item(lfudfp_pkg::OP_DISCARD, 32'hFFFF_FFFF, 1'b1);
		send_item(lfudfp_pkg::OP_CLEAN, 32'h0, 1'b0);
		send_item(lfudfp_pkg::OP_REFERENCE, 32'h0, 1'b0);
		send_item(lfudfp_pkg::OP_REFERENCE, 32'hFFFF_FFFF, 1'b1);
		send_item(lfudfp_pkg::OP_REFERENCE, 32'h0, 1'b1);
		send_item(lfudfp_pkg::OP_CLEAN, 32'h0, 1'b0);
		send_item(lfudfp_pkg::OP_CLEAN, 32'h1234_5678, 1'b0);
		send_item(lfudfp_pkg::OP_DISCARD, 32'hFFFF_FFFF, 1'b0);
		send_item(lfudfp_pkg::OP_EVICT, 32'h0, 1'b0);
		send_item(lfudfp_pkg::OP_EVICT, 32'h0, 1'b0);

		// Capacity zero acts as one: each miss after the first evicts the single resident page
		set_capacity(5'd0);
		for (int i = 0; i < 4; i++)
			send_item(lfudfp_pkg::OP_REFERENCE, 32'hA5A5_0000 + i, i[0]);
		// Capacity above the entry count acts as the entry count
		set_capacity(5'd31);
		for (int i = 0; i < 20; i++)
			send_item(lfudfp_pkg::OP_REFERENCE, 32'h5A5A_0000 + i, i[1]);

		// Lowered capacity below occupancy
		set_capacity(5'd3);
		random_phase(300);
		set_capacity(5'd1);
		random_phase(150);

		// Sender holds off until everything has come back
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		set_capacity(5'd16);
		random_phase(400);
		set_capacity(5'd8);
		random_phase(300);
		set_capacity(5'd31);
		random_phase(230);

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items over capacities 0, 1, 3, 8, 16 and 31,", item_total);
		$display("covering hits, misses, discards, evictions and cleans.");
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
